@@ rtl/cau_pkg.sv @@
`default_nettype none
package cau_pkg;

   // width of every operand and result port
   localparam int unsigned PORT_WIDTH = 32;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   // control that travels with each item along the divider chain
   typedef struct packed {
      logic valid;
      logic is_div;
      logic neg_re;
      logic neg_im;
      logic big_re;
      logic big_im;
      logic ovf;
      logic dz;
   } ctrl_type;

endpackage
`default_nettype wire

@@ rtl/cau_div_cell.sv @@
`default_nettype none
module cau_div_cell #(
   parameter int DW    = 32,
   parameter int RW    = 113,
   parameter int SHIFT = 0
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire cau_pkg::ctrl_type  ctrl_in,
   input  wire logic [2*DW-1:0]    den_in,
   input  wire logic [RW-1:0]      rem_re_in,
   input  wire logic [RW-1:0]      rem_im_in,
   input  wire logic [DW-1:0]      q_re_in,
   input  wire logic [DW-1:0]      q_im_in,
   output cau_pkg::ctrl_type       ctrl_out,
   output logic [2*DW-1:0]         den_out,
   output logic [RW-1:0]           rem_re_out,
   output logic [RW-1:0]           rem_im_out,
   output logic [DW-1:0]           q_re_out,
   output logic [DW-1:0]           q_im_out
);
   import cau_pkg::*;

   ctrl_type          ctrl_ff;
   logic [2*DW-1:0]   den_ff;
   logic [RW-1:0]     rem_re_ff, rem_im_ff, rem_re_nxt_in, rem_im_nxt_in;
   logic [DW-1:0]     q_re_ff, q_im_ff, q_re_nxt_in, q_im_nxt_in;
   logic [RW-1:0]     dsh;
   logic [DW-1:0]     qbit;

   // try one shifted divisor on both parts
   always_comb begin
      dsh           = RW'(den_in) << SHIFT;
      qbit          = DW'(1) << SHIFT;
      rem_re_nxt_in = rem_re_in;
      rem_im_nxt_in = rem_im_in;
      q_re_nxt_in   = q_re_in;
      q_im_nxt_in   = q_im_in;
      if (ctrl_in.is_div) begin
         if (rem_re_in >= dsh) begin
            rem_re_nxt_in = rem_re_in - dsh;
            q_re_nxt_in   = q_re_in | qbit;
         end
         if (rem_im_in >= dsh) begin
            rem_im_nxt_in = rem_im_in - dsh;
            q_im_nxt_in   = q_im_in | qbit;
         end
      end
   end

   // advance the item to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= ctrl_in;
      end
      if (advance) begin
         den_ff    <= den_in;
         rem_re_ff <= rem_re_nxt_in;
         rem_im_ff <= rem_im_nxt_in;
         q_re_ff   <= q_re_nxt_in;
         q_im_ff   <= q_im_nxt_in;
      end
   end

   assign ctrl_out   = ctrl_ff;
   assign den_out    = den_ff;
   assign rem_re_out = rem_re_ff;
   assign rem_im_out = rem_im_ff;
   assign q_re_out   = q_re_ff;
   assign q_im_out   = q_im_ff;

endmodule
`default_nettype wire

@@ rtl/complex_arithmetic_unit.sv @@
`default_nettype none
// Complex add, subtract, multiply and divide on signed fixed-point operands
// (DATA_WIDTH bits, FRAC_BITS fraction bits, taken from the low bits of the
// 32-bit ports and sign-extended back on the result). One item is accepted
// per cycle while the result is not stalled; every item passes through the
// chain of restoring-divider cells, one quotient bit per cell, whatever its
// command. Parts saturate and raise overflow; a zero divisor gives zero
// parts and div_zero. A stalled result holds the whole pipeline.
module complex_arithmetic_unit #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [1:0]                      req_command,
   input  wire logic [cau_pkg::PORT_WIDTH-1:0]  req_a_re,
   input  wire logic [cau_pkg::PORT_WIDTH-1:0]  req_a_im,
   input  wire logic [cau_pkg::PORT_WIDTH-1:0]  req_b_re,
   input  wire logic [cau_pkg::PORT_WIDTH-1:0]  req_b_im,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [cau_pkg::PORT_WIDTH-1:0]       rsp_res_re,
   output logic [cau_pkg::PORT_WIDTH-1:0]       rsp_res_im,
   output logic                                 rsp_overflow,
   output logic                                 rsp_div_zero
);
   import cau_pkg::*;

   localparam int DW  = DATA_WIDTH;
   localparam int PW  = 2 * DW;
   localparam int SW  = 2 * DW + 1;
   localparam int NW  = 2 * DW + FRAC_BITS;
   localparam int RW  = ((NW > 3 * DW) ? NW : 3 * DW) + 1;
   localparam logic signed [SW-1:0] MAXP = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
   localparam logic signed [SW-1:0] MINN = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};
   localparam logic [DW-1:0] QMAXP = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] QMINN = {1'b1, {(DW-1){1'b0}}};

   // saturate a wide signed value: {overflow, value}
   function automatic logic [DW:0] sat(input logic signed [SW-1:0] v);
      logic [DW:0] r;
      if (v > MAXP) r = {1'b1, QMAXP};
      else if (v < MINN) r = {1'b1, QMINN};
      else r = {1'b0, v[DW-1:0]};
      return r;
   endfunction

   logic advance;
   logic rsp_valid_ff;
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // stage 1: capture operands
   logic                  v1_ff;
   cmd_type               cmd1_ff;
   logic signed [DW-1:0]  ar1_ff, ai1_ff, br1_ff, bi1_ff;

   // stage 2: products and add/sub sums
   logic                  v2_ff;
   cmd_type               cmd2_ff;
   logic signed [PW-1:0]  prr_ff, pii_ff, pir_ff, pri_ff, drr_ff, dii_ff;
   logic signed [DW:0]    as_re_ff, as_im_ff;

   // stage 3: sums of products
   logic                  v3_ff;
   cmd_type               cmd3_ff;
   logic signed [SW-1:0]  s_re_ff, s_im_ff, s_re_in, s_im_in;
   logic [PW-1:0]         den3_ff;
   logic signed [DW:0]    as_re3_ff, as_im3_ff;

   // stage 4: sign and magnitude, direct results
   ctrl_type              c4_in, c4_ff;
   logic [PW-1:0]         den4_ff;
   logic [RW-1:0]         r4_re_in, r4_im_in, r4_re_ff, r4_im_ff;
   logic [DW-1:0]         q4_re_in, q4_im_in, q4_re_ff, q4_im_ff;
   logic signed [SW-1:0]  mag_re, mag_im, sh_re, sh_im;
   logic [DW:0]           st_re, st_im;

   // stage 5: quotient range check
   ctrl_type              c5_in, c5_ff;
   logic [PW-1:0]         den5_ff;
   logic [RW-1:0]         r5_re_ff, r5_im_ff, dtop;
   logic [DW-1:0]         q5_re_ff, q5_im_ff;

   always_comb begin
      s_re_in = '0;
      s_im_in = '0;
      case (cmd2_ff)
         CMD_MUL: begin
            s_re_in = {prr_ff[PW-1], prr_ff} - {pii_ff[PW-1], pii_ff};
            s_im_in = {pir_ff[PW-1], pir_ff} + {pri_ff[PW-1], pri_ff};
         end
         CMD_DIV: begin
            s_re_in = {prr_ff[PW-1], prr_ff} + {pii_ff[PW-1], pii_ff};
            s_im_in = {pir_ff[PW-1], pir_ff} - {pri_ff[PW-1], pri_ff};
         end
         default: begin
            s_re_in = '0;
            s_im_in = '0;
         end
      endcase
   end

   // stage 4 setup: pick result path per command
   always_comb begin
      mag_re   = s_re_ff[SW-1] ? -s_re_ff : s_re_ff;
      mag_im   = s_im_ff[SW-1] ? -s_im_ff : s_im_ff;
      sh_re    = s_re_ff >>> FRAC_BITS;
      sh_im    = s_im_ff >>> FRAC_BITS;
      st_re    = '0;
      st_im    = '0;
      c4_in    = '0;
      c4_in.valid = v3_ff;
      r4_re_in = RW'(mag_re[PW-1:0]) << FRAC_BITS;
      r4_im_in = RW'(mag_im[PW-1:0]) << FRAC_BITS;
      q4_re_in = '0;
      q4_im_in = '0;
      case (cmd3_ff)
         CMD_ADD, CMD_SUB: begin
            st_re = sat(SW'(as_re3_ff));
            st_im = sat(SW'(as_im3_ff));
         end
         CMD_MUL: begin
            st_re = sat(sh_re);
            st_im = sat(sh_im);
         end
         CMD_DIV: begin
            if (den3_ff == '0) begin
               c4_in.dz = 1'b1;
            end else begin
               c4_in.is_div = 1'b1;
               c4_in.neg_re = s_re_ff[SW-1];
               c4_in.neg_im = s_im_ff[SW-1];
            end
         end
         default: begin
            st_re = '0;
            st_im = '0;
         end
      endcase
      if (!c4_in.is_div && !c4_in.dz) begin
         c4_in.ovf = st_re[DW] | st_im[DW];
         q4_re_in  = st_re[DW-1:0];
         q4_im_in  = st_im[DW-1:0];
      end
   end

   // stage 5 setup: flag quotients that cannot fit the cell chain
   always_comb begin
      dtop  = RW'(den4_ff) << DW;
      c5_in = c4_ff;
      c5_in.big_re = c4_ff.is_div && (r4_re_ff >= dtop);
      c5_in.big_im = c4_ff.is_div && (r4_im_ff >= dtop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         c4_ff <= '0;
         c5_ff <= '0;
      end else if (advance) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         c4_ff <= c4_in;
         c5_ff <= c5_in;
      end
      if (advance) begin
         cmd1_ff   <= cmd_type'(req_command);
         ar1_ff    <= req_a_re[DW-1:0];
         ai1_ff    <= req_a_im[DW-1:0];
         br1_ff    <= req_b_re[DW-1:0];
         bi1_ff    <= req_b_im[DW-1:0];
         cmd2_ff   <= cmd1_ff;
         prr_ff    <= PW'(ar1_ff) * PW'(br1_ff);
         pii_ff    <= PW'(ai1_ff) * PW'(bi1_ff);
         pir_ff    <= PW'(ai1_ff) * PW'(br1_ff);
         pri_ff    <= PW'(ar1_ff) * PW'(bi1_ff);
         drr_ff    <= PW'(br1_ff) * PW'(br1_ff);
         dii_ff    <= PW'(bi1_ff) * PW'(bi1_ff);
         as_re_ff  <= (cmd1_ff == CMD_SUB) ? ((DW+1)'(ar1_ff) - (DW+1)'(br1_ff))
                                           : ((DW+1)'(ar1_ff) + (DW+1)'(br1_ff));
         as_im_ff  <= (cmd1_ff == CMD_SUB) ? ((DW+1)'(ai1_ff) - (DW+1)'(bi1_ff))
                                           : ((DW+1)'(ai1_ff) + (DW+1)'(bi1_ff));
         cmd3_ff   <= cmd2_ff;
         s_re_ff   <= s_re_in;
         s_im_ff   <= s_im_in;
         den3_ff   <= PW'(drr_ff) + PW'(dii_ff);
         as_re3_ff <= as_re_ff;
         as_im3_ff <= as_im_ff;
         den4_ff   <= den3_ff;
         r4_re_ff  <= r4_re_in;
         r4_im_ff  <= r4_im_in;
         q4_re_ff  <= q4_re_in;
         q4_im_ff  <= q4_im_in;
         den5_ff   <= den4_ff;
         r5_re_ff  <= r4_re_ff;
         r5_im_ff  <= r4_im_ff;
         q5_re_ff  <= q4_re_ff;
         q5_im_ff  <= q4_im_ff;
      end
   end

   // divider chain, most significant quotient bit first
   ctrl_type        cc   [0:DW];
   logic [PW-1:0]   cden [0:DW];
   logic [RW-1:0]   crre [0:DW];
   logic [RW-1:0]   crim [0:DW];
   logic [DW-1:0]   cqre [0:DW];
   logic [DW-1:0]   cqim [0:DW];

   assign cc[0]   = c5_ff;
   assign cden[0] = den5_ff;
   assign crre[0] = r5_re_ff;
   assign crim[0] = r5_im_ff;
   assign cqre[0] = q5_re_ff;
   assign cqim[0] = q5_im_ff;

   for (genvar i = 0; i < DW; i++) begin : g_cell
      cau_div_cell #(.DW(DW), .RW(RW), .SHIFT(DW - 1 - i)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .ctrl_in    (cc[i]),
         .den_in     (cden[i]),
         .rem_re_in  (crre[i]),
         .rem_im_in  (crim[i]),
         .q_re_in    (cqre[i]),
         .q_im_in    (cqim[i]),
         .ctrl_out   (cc[i+1]),
         .den_out    (cden[i+1]),
         .rem_re_out (crre[i+1]),
         .rem_im_out (crim[i+1]),
         .q_re_out   (cqre[i+1]),
         .q_im_out   (cqim[i+1])
      );
   end

   // final saturation of quotients
   ctrl_type       cl;
   logic [DW-1:0]  fre, fim;
   logic           fovf;
   always_comb begin
      cl   = cc[DW];
      fre  = cqre[DW];
      fim  = cqim[DW];
      fovf = cl.ovf;
      if (cl.is_div) begin
         if (!cl.neg_re) begin
            if (cl.big_re || cqre[DW][DW-1]) begin
               fre = QMAXP; fovf = 1'b1;
            end
         end else if (cl.big_re || cqre[DW] > QMINN) begin
            fre = QMINN; fovf = 1'b1;
         end else begin
            fre = -cqre[DW];
         end
         if (!cl.neg_im) begin
            if (cl.big_im || cqim[DW][DW-1]) begin
               fim = QMAXP; fovf = 1'b1;
            end
         end else if (cl.big_im || cqim[DW] > QMINN) begin
            fim = QMINN; fovf = 1'b1;
         end else begin
            fim = -cqim[DW];
         end
      end
   end

   // output register
   logic [PORT_WIDTH-1:0] re_ff, im_ff;
   logic                  ovf_ff, dz_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= cl.valid;
      end
      if (advance) begin
         re_ff  <= PORT_WIDTH'(signed'(fre));
         im_ff  <= PORT_WIDTH'(signed'(fim));
         ovf_ff <= fovf;
         dz_ff  <= cl.dz;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_res_re   = re_ff;
   assign rsp_res_im   = im_ff;
   assign rsp_overflow = ovf_ff;
   assign rsp_div_zero = dz_ff;

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
`default_nettype none
module testbench;
   import cau_pkg::*;

   localparam int DW = 32;
   localparam int FB = 16;
   localparam int LATENCY = DW + 6;

   typedef struct {
      logic          hold;   // pause until all results are back
      cmd_type       cmd;
      logic [31:0]   a_re, a_im, b_re, b_im;
   } op_item_type;

   typedef struct {
      logic [31:0]   re, im;
      logic          ovf, dz;
   } cplx_result_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic [1:0]    req_command = CMD_ADD;
   logic [31:0]   req_a_re = '0, req_a_im = '0, req_b_re = '0, req_b_im = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [31:0]   rsp_res_re, rsp_res_im;
   logic          rsp_overflow, rsp_div_zero;

   op_item_type      pending_ops[$];
   cplx_result_type  expected_results[$];
   int               accepted_count = 0;
   int               error_count = 0;
   logic             req_taken = 1'b0;

   complex_arithmetic_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_command(req_command),
      .req_a_re(req_a_re), .req_a_im(req_a_im), .req_b_re(req_b_re), .req_b_im(req_b_im),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_res_re(rsp_res_re), .rsp_res_im(rsp_res_im),
      .rsp_overflow(rsp_overflow), .rsp_div_zero(rsp_div_zero)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // clamp an exact value to the 32-bit signed range
   function automatic logic [31:0] clamp_part(input logic signed [127:0] v, inout logic ovf);
      logic signed [127:0] hi, lo;
      hi = 128'sd2147483647;
      lo = -128'sd2147483648;
      if (v > hi) begin
         ovf = 1'b1;
         return hi[31:0];
      end
      if (v < lo) begin
         ovf = 1'b1;
         return lo[31:0];
      end
      return v[31:0];
   endfunction

   function automatic cplx_result_type compute_complex(input op_item_type op);
      cplx_result_type r;
      logic signed [127:0] ar, ai, br, bi, sr, si, den;
      ar = {{96{op.a_re[31]}}, op.a_re};
      ai = {{96{op.a_im[31]}}, op.a_im};
      br = {{96{op.b_re[31]}}, op.b_re};
      bi = {{96{op.b_im[31]}}, op.b_im};
      r.ovf = 1'b0;
      r.dz = 1'b0;
      r.re = '0;
      r.im = '0;
      case (op.cmd)
         CMD_ADD: begin
            sr = ar + br;
            si = ai + bi;
         end
         CMD_SUB: begin
            sr = ar - br;
            si = ai - bi;
         end
         CMD_MUL: begin
            // arithmetic shift floors toward minus infinity
            sr = (ar * br - ai * bi) >>> FB;
            si = (ai * br + ar * bi) >>> FB;
         end
         default: begin
            den = br * br + bi * bi;
            if (den == 0) begin
               r.dz = 1'b1;
               return r;
            end
            // signed division truncates toward zero
            sr = ((ar * br + ai * bi) <<< FB) / den;
            si = ((ai * br - ar * bi) <<< FB) / den;
         end
      endcase
      r.re = clamp_part(sr, r.ovf);
      r.im = clamp_part(si, r.ovf);
      return r;
   endfunction

   function automatic logic [31:0] pick_part();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 6))
         0, 1: ;
         2: v = {{12{v[19]}}, v[19:0]};
         3: v = {{8{v[23]}}, v[23:0]};
         4: case ($urandom_range(0, 5))
               0: v = 32'h8000_0000;
               1: v = 32'h7FFF_FFFF;
               2: v = 32'h0000_0000;
               3: v = 32'hFFFF_FFFF;
               4: v = 32'h0001_0000;
               default: v = 32'hFFFF_0000;
            endcase
         5: v = {{15{v[16]}}, v[16:0]};
         default: v = {{4{v[27]}}, v[27:0]};
      endcase
      return v;
   endfunction

   function automatic op_item_type make_op(cmd_type c, logic [31:0] a0, logic [31:0] a1,
                                            logic [31:0] b0, logic [31:0] b1);
      op_item_type op;
      op.hold = 1'b0;
      op.cmd = c;
      op.a_re = a0;
      op.a_im = a1;
      op.b_re = b0;
      op.b_im = b1;
      return op;
   endfunction

   function automatic int sender_idle_pct();
      if (accepted_count < 500) return 18;
      if (accepted_count < 1000) return 80;
      return 0;
   endfunction

   function automatic int receiver_idle_pct();
      if (accepted_count < 500) return 80;
      if (accepted_count < 1000) return 18;
      return 0;
   endfunction

   // fill the stimulus, then wait for the pipeline to drain and report
   initial begin
      op_item_type op;
      logic [31:0] mx, mn;
      mx = 32'h7FFF_FFFF;
      mn = 32'h8000_0000;
      pending_ops.push_back(make_op(CMD_ADD, mx, mn, 32'd1, 32'hFFFF_FFFF));
      pending_ops.push_back(make_op(CMD_ADD, mn, mx, mn, mx));
      pending_ops.push_back(make_op(CMD_ADD, 32'd0, 32'd0, 32'd0, 32'd0));
      pending_ops.push_back(make_op(CMD_SUB, mn, mx, 32'd1, 32'hFFFF_FFFF));
      pending_ops.push_back(make_op(CMD_SUB, mx, mn, mn, mx));
      pending_ops.push_back(make_op(CMD_SUB, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd1));
      pending_ops.push_back(make_op(CMD_MUL, mn, mn, mn, mn));
      pending_ops.push_back(make_op(CMD_MUL, mx, mx, mx, mn));
      pending_ops.push_back(make_op(CMD_MUL, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd0));
      pending_ops.push_back(make_op(CMD_MUL, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 32'd3));
      pending_ops.push_back(make_op(CMD_DIV, 32'h0001_0000, 32'd5, 32'd0, 32'd0));
      pending_ops.push_back(make_op(CMD_DIV, mx, mn, mn, mn));
      pending_ops.push_back(make_op(CMD_DIV, mx, mx, 32'd1, 32'd0));
      pending_ops.push_back(make_op(CMD_DIV, 32'hFFFF_FFFF, 32'd0, 32'h0003_0000, 32'd0));
      pending_ops.push_back(make_op(CMD_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0000_8000,
                                    32'hFFFF_8000));
      pending_ops.push_back(make_op(CMD_DIV, mn, 32'd0, mn, 32'd0));
      for (int i = 0; i < 1500; i++) begin
         op = make_op(cmd_type'($urandom_range(0, 3)), pick_part(), pick_part(),
                      pick_part(), pick_part());
         if (op.cmd == CMD_DIV && $urandom_range(0, 19) == 0) begin
            op.b_re = '0;
            op.b_im = '0;
         end
         op.hold = (i == 700);
         pending_ops.push_back(op);
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (pending_ops.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (LATENCY + 20) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #600000;
      $display("status: fail");
      $finish;
   end

   // drive items on the falling edge
   always @(negedge clock) begin
      if (!reset && !(req_valid && !req_taken)) begin
         if (pending_ops.size() != 0 && pending_ops[0].hold && expected_results.size() == 0)
            pending_ops[0].hold = 1'b0;
         if (pending_ops.size() != 0 && !pending_ops[0].hold &&
             $urandom_range(0, 99) >= sender_idle_pct()) begin
            req_valid   <= 1'b1;
            req_command <= pending_ops[0].cmd;
            req_a_re    <= pending_ops[0].a_re;
            req_a_im    <= pending_ops[0].a_im;
            req_b_re    <= pending_ops[0].b_re;
            req_b_im    <= pending_ops[0].b_im;
            void'(pending_ops.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
      req_taken = 1'b0;
      rsp_ready <= !reset && ($urandom_range(0, 99) >= receiver_idle_pct());
   end

   // record accepted items and check results on the rising edge
   always @(posedge clock) begin
      cplx_result_type want;
      if (!reset && req_valid && req_ready) begin
         req_taken = 1'b1;
         accepted_count++;
         expected_results.push_back(compute_complex(make_op(cmd_type'(req_command),
                                    req_a_re, req_a_im, req_b_re, req_b_im)));
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            error_count++;
            $error("result with no item outstanding");
         end else begin
            want = expected_results.pop_front();
            if (rsp_res_re !== want.re) begin
               error_count++;
               $error("res_re expected %h actual %h", want.re, rsp_res_re);
            end
            if (rsp_res_im !== want.im) begin
               error_count++;
               $error("res_im expected %h actual %h", want.im, rsp_res_im);
            end
            if (rsp_overflow !== want.ovf) begin
               error_count++;
               $error("overflow expected %b actual %b", want.ovf, rsp_overflow);
            end
            if (rsp_div_zero !== want.dz) begin
               error_count++;
               $error("div_zero expected %b actual %b", want.dz, rsp_div_zero);
            end
         end
      end
   end

endmodule
`default_nettype wire
